// ===== src/b2da_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared constants, types and helper functions for the binary to decimal
// ASCII converter.
// ----------------------------------------------------------------------------
package b2da_pkg;

  localparam int MAX_DIGITS = 8;
  localparam int VALUE_W    = 16;
  localparam int HALF_W     = VALUE_W / 2;
  localparam int BCD_DIGITS = 5;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int LO_BCD_W   = 12;
  localparam int BCD_IDX_W  = $clog2(BCD_DIGITS);
  localparam int CNT_W      = 4;
  localparam int N_W        = $clog2(MAX_DIGITS + 1);
  localparam int K_W        = $clog2(MAX_DIGITS);
  localparam int CHAR_W     = 6;
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 3;

  localparam logic [CNT_W-1:0]  DIGIT_COUNT_RESET = 4'd5;
  localparam logic [7:0]        ASCII_ZERO        = 8'h30;
  localparam logic [ADDR_W-1:0] ADDR_DIGIT_COUNT  = 3'd0;

  typedef struct packed {
    logic             valid;
    logic [BCD_W-1:0] bcd;
  } bcd_item_t;

  // one shift-and-add-3 step over the whole digit chain
  function automatic logic [BCD_W-1:0] b2da_step(input logic [BCD_W-1:0] bcd,
                                                 input logic bit_in);
    logic [BCD_W-1:0] adj;
    logic [3:0]       dig;
    for (int j = 0; j < BCD_DIGITS; j++) begin
      dig = bcd[4*j +: 4];
      if (dig >= 4'd5) begin
        dig = dig + 4'd3;
      end
      adj[4*j +: 4] = dig;
    end
    return {adj[BCD_W-2:0], bit_in};
  endfunction

  function automatic logic [N_W-1:0] b2da_eff_count(input logic [CNT_W-1:0] cnt);
    logic [N_W-1:0] n;
    if (cnt == '0) begin
      n = N_W'(1);
    end else if (int'(cnt) > MAX_DIGITS) begin
      n = N_W'(MAX_DIGITS);
    end else begin
      n = N_W'(cnt);
    end
    return n;
  endfunction

endpackage

// ===== src/b2da_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2da_if
// Valid/ready channels for the input value and the digit items.
// ----------------------------------------------------------------------------
interface b2da_in_if;
  import b2da_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface b2da_out_if;
  import b2da_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] digit_char;
  logic              last_digit;
  logic              overflow;

  modport source (output valid, output digit_char, output last_digit, output overflow,
                  input ready);
  modport sink   (input valid, input digit_char, input last_digit, input overflow,
                  output ready);
endinterface

// ===== src/b2da_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2da_cfg
// APB register block holding the digit count.
// ----------------------------------------------------------------------------
module b2da_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [b2da_pkg::ADDR_W-1:0]  paddr,
  input  logic [b2da_pkg::DATA_W-1:0]  pwdata,
  output logic [b2da_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output logic [b2da_pkg::N_W-1:0]     count_o
);
  import b2da_pkg::*;

  logic [CNT_W-1:0] digit_count_q, digit_count_d;
  logic             wr_en;
  logic             sel_count;

  assign pready    = 1'b1;
  assign sel_count = (paddr[ADDR_W-1] == ADDR_DIGIT_COUNT[ADDR_W-1]);
  assign wr_en     = psel && penable && pwrite && pready && sel_count;

  always_comb begin
    digit_count_d = digit_count_q;
    if (wr_en) begin
      digit_count_d = pwdata[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_count_q <= DIGIT_COUNT_RESET;
    end else begin
      digit_count_q <= digit_count_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_count) begin
      prdata = DATA_W'(digit_count_q);
    end
  end

  assign count_o = b2da_eff_count(digit_count_q);

endmodule

// ===== src/b2da_conv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2da_conv
// Two-stage double dabble: the high byte is converted in the first stage,
// the low byte is shifted in during the second.
// ----------------------------------------------------------------------------
module b2da_conv (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [b2da_pkg::VALUE_W-1:0]  in_value_i,
  output logic                          in_ready_o,
  output b2da_pkg::bcd_item_t           bcd_o,
  input  logic                          bcd_ready_i
);
  import b2da_pkg::*;

  logic                s1_valid_q, s1_valid_d;
  logic [LO_BCD_W-1:0] s1_bcd_q;
  logic [HALF_W-1:0]   s1_lo_q;
  logic                s2_valid_q, s2_valid_d;
  logic [BCD_W-1:0]    s2_bcd_q;
  logic [BCD_W-1:0]    hi_bcd;
  logic [BCD_W-1:0]    full_bcd;
  logic                s1_load;
  logic                s2_load;
  logic                s2_ready;

  always_comb begin
    hi_bcd = '0;
    for (int i = 0; i < HALF_W; i++) begin
      hi_bcd = b2da_step(hi_bcd, in_value_i[VALUE_W-1-i]);
    end
  end

  always_comb begin
    full_bcd = BCD_W'(s1_bcd_q);
    for (int i = 0; i < HALF_W; i++) begin
      full_bcd = b2da_step(full_bcd, s1_lo_q[HALF_W-1-i]);
    end
  end

  assign s2_ready   = !s2_valid_q || bcd_ready_i;
  assign in_ready_o = !s1_valid_q || s2_ready;
  assign s1_load    = in_valid_i && in_ready_o;
  assign s2_load    = s1_valid_q && s2_ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_ready_o) begin
      s1_valid_d = in_valid_i;
    end
    s2_valid_d = s2_valid_q;
    if (s2_ready) begin
      s2_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_bcd_q <= hi_bcd[LO_BCD_W-1:0];
      s1_lo_q  <= in_value_i[HALF_W-1:0];
    end
    if (s2_load) begin
      s2_bcd_q <= full_bcd;
    end
  end

  assign bcd_o.valid = s2_valid_q;
  assign bcd_o.bcd   = s2_bcd_q;

endmodule

// ===== src/b2da_ser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2da_ser
// Digit serialiser: holds one converted value and sends its digits as ASCII
// items, most significant first, with overflow and last-digit marks.
// ----------------------------------------------------------------------------
module b2da_ser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  b2da_pkg::bcd_item_t          bcd_i,
  output logic                         bcd_ready_o,
  input  logic [b2da_pkg::N_W-1:0]     count_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [b2da_pkg::CHAR_W-1:0]  digit_char_o,
  output logic                         last_digit_o,
  output logic                         overflow_o
);
  import b2da_pkg::*;

  logic                             busy_q, busy_d;
  logic [K_W-1:0]                   k_q, k_d;
  logic [N_W-1:0]                   n_q;
  logic                             ovf_q;
  logic [BCD_DIGITS-1:0][3:0]       bcd_q;
  logic [BCD_DIGITS-1:0][3:0]       in_digits;
  logic                             ovf_in;
  logic                             load;
  logic                             out_acc;
  logic [N_W-1:0]                   pos;
  logic [3:0]                       digit;

  assign in_digits = bcd_i.bcd;

  // digits above the configured count mean the value does not fit
  always_comb begin
    ovf_in = 1'b0;
    for (int j = 0; j < BCD_DIGITS; j++) begin
      if ((N_W'(j) >= count_i) && (in_digits[j] != 4'd0)) begin
        ovf_in = 1'b1;
      end
    end
  end

  assign last_digit_o = ({1'b0, k_q} == N_W'(n_q - N_W'(1)));
  assign out_acc      = busy_q && out_ready_i;
  assign bcd_ready_o  = !busy_q || (out_ready_i && last_digit_o);
  assign load         = bcd_i.valid && bcd_ready_o;

  always_comb begin
    busy_d = busy_q;
    k_d    = k_q;
    if (load) begin
      busy_d = 1'b1;
      k_d    = '0;
    end else if (out_acc) begin
      if (last_digit_o) begin
        busy_d = 1'b0;
      end else begin
        k_d = k_q + K_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= '0;
    end else begin
      busy_q <= busy_d;
      k_q    <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bcd_q <= in_digits;
      n_q   <= count_i;
      ovf_q <= ovf_in;
    end
  end

  // position counted from the least significant digit
  assign pos = N_W'(n_q - N_W'(1) - N_W'(k_q));

  always_comb begin
    digit = 4'd0;
    if (int'(pos) < BCD_DIGITS) begin
      digit = bcd_q[pos[BCD_IDX_W-1:0]];
    end
  end

  assign out_valid_o  = busy_q;
  assign digit_char_o = CHAR_W'(ASCII_ZERO) + CHAR_W'(digit);
  assign overflow_o   = ovf_q;

endmodule

// ===== src/binary_to_decimal_ascii.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Converts a 16-bit unsigned value into a run of ASCII decimal digits.
// ----------------------------------------------------------------------------
// Each accepted value produces n digit items, n being the digit_count
// register (0 reads as 1, above 8 reads as 8), most significant digit first,
// the last one marked by last_digit. overflow is set on every item of a run
// when the value is 10^n or more; the digits are then the value modulo 10^n.
// Conversion runs through two register stages (high byte, then low byte)
// before the digit serialiser takes the value. The digit serialiser sends
// one item per cycle on the output channel while the output is ready, and
// takes the next value as the last digit of a run is accepted; up to two
// further values wait in the conversion stages while a run is being sent.
// digit_count sits at byte address 0 of the APB port and resets to 5.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  b2da_in_if.sink                      inp_i,
  b2da_out_if.source                   out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [b2da_pkg::ADDR_W-1:0]  paddr,
  input  logic [b2da_pkg::DATA_W-1:0]  pwdata,
  output logic [b2da_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import b2da_pkg::*;

  logic [N_W-1:0] count;
  bcd_item_t      bcd_item;
  logic           bcd_ready;

  b2da_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .count_o (count)
  );

  b2da_conv u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (inp_i.valid),
    .in_value_i  (inp_i.value),
    .in_ready_o  (inp_i.ready),
    .bcd_o       (bcd_item),
    .bcd_ready_i (bcd_ready)
  );

  b2da_ser u_ser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .bcd_i        (bcd_item),
    .bcd_ready_o  (bcd_ready),
    .count_i      (count),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .digit_char_o (out_o.digit_char),
    .last_digit_o (out_o.last_digit),
    .overflow_o   (out_o.overflow)
  );

endmodule

// ===== src/b2da_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2da_chk
// Port-level checks on the digit output channel of the converter.
// ----------------------------------------------------------------------------
module b2da_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [b2da_pkg::CHAR_W-1:0]  digit_char_i,
  input logic                         last_digit_i,
  input logic                         overflow_i
);
  import b2da_pkg::*;

  // stalled item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(digit_char_i)
      && $stable(last_digit_i) && $stable(overflow_i))
    else $error("stalled digit item changed");

  // a run continues straight after a non-final digit with the same flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_digit_i |=>
      out_valid_i && (overflow_i == $past(overflow_i)))
    else $error("digit run broken or overflow flag changed within a run");

  // only decimal digit codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (digit_char_i >= CHAR_W'(ASCII_ZERO))
      && (digit_char_i <= CHAR_W'(ASCII_ZERO) + CHAR_W'(9)))
    else $error("digit code outside 0 to 9");

endmodule

bind binary_to_decimal_ascii b2da_chk u_b2da_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .digit_char_i (out_o.digit_char),
  .last_digit_i (out_o.last_digit),
  .overflow_i   (out_o.overflow)
);

// ===== dv/tb_binary_to_decimal_ascii.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_to_decimal_ascii
// Self-checking bench for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
// Values go in on the input channel and every accepted value is converted
// here by a shift-and-add-3 model at the current digit count. The digit
// items it yields are queued and each item leaving the block is compared
// against the oldest queued one. digit_count is changed over the APB port
// only when the block is idle, and read back after every write. The run
// covers directed corner values, a long output stall that fills the block,
// sender pauses and a random part spread over several digit counts.
// ----------------------------------------------------------------------------
module tb_binary_to_decimal_ascii;
  import b2da_pkg::*;

  localparam int              CYCLE_LIMIT  = 1_000_000;
  localparam int              DRAIN_CYCLES = 8;
  localparam int              REPORT_CAP   = 100;
  localparam logic [ADDR_W-1:0] ADDR_UNUSED = 3'd4;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last_digit;
    logic              overflow;
  } digit_item_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  b2da_in_if  inp ();
  b2da_out_if outp ();

  binary_to_decimal_ascii dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .inp_i   (inp),
    .out_o   (outp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  digit_item_t      pending_digits[$];
  logic [CNT_W-1:0] digit_count_cfg;
  int               error_count;
  int               cycle_count;
  int               next_gap;
  int               sink_hold_req;
  bit               src_gaps_on;
  bit               sink_gaps_on;

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (error_count < REPORT_CAP) begin
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    end
    error_count++;
  endtask

  // shift-and-add-3 over the effective number of digits
  function automatic void convert_to_digits(input logic [VALUE_W-1:0] value);
    logic [3:0]         bcd [MAX_DIGITS];
    logic [3:0]         dig;
    logic [VALUE_W-1:0] shreg;
    logic               carry;
    logic               ovf;
    int                 n;
    digit_item_t        item;
    if (digit_count_cfg == '0) begin
      n = 1;
    end else if (int'(digit_count_cfg) > MAX_DIGITS) begin
      n = MAX_DIGITS;
    end else begin
      n = int'(digit_count_cfg);
    end
    for (int k = 0; k < MAX_DIGITS; k++) begin
      bcd[k] = 4'd0;
    end
    shreg = value;
    ovf   = 1'b0;
    for (int b = 0; b < VALUE_W; b++) begin
      carry = shreg[VALUE_W-1];
      shreg = shreg << 1;
      for (int k = n - 1; k >= 0; k--) begin
        dig = bcd[k];
        if (dig >= 4'd5) begin
          dig = dig + 4'd3;
        end
        bcd[k] = {dig[2:0], carry};
        carry  = dig[3];
      end
      ovf = ovf | carry;
    end
    for (int k = 0; k < n; k++) begin
      item.digit_char = CHAR_W'(ASCII_ZERO + {4'd0, bcd[k]});
      item.last_digit = (k == n - 1);
      item.overflow   = ovf;
      pending_digits.push_back(item);
    end
  endfunction

  function automatic int pick_gap(input bit enabled);
    int r;
    if (!enabled) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 75) begin
      return 0;
    end
    if (r < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [VALUE_W-1:0] random_value();
    int          pick;
    int unsigned pow;
    pick = $urandom_range(0, 9);
    pow  = 1;
    if (pick < 5) begin
      return VALUE_W'($urandom);
    end
    if (pick < 8) begin
      // around a power of ten
      repeat ($urandom_range(0, 4)) pow = pow * 10;
      return VALUE_W'(pow + $urandom_range(0, 2) - 1);
    end
    if (pick == 8) begin
      return VALUE_W'($urandom_range(0, 99));
    end
    return 16'hFFFF - VALUE_W'($urandom_range(0, 3));
  endfunction

  // valid stays high when the next item follows with no gap
  task automatic send_value(input logic [VALUE_W-1:0] value);
    repeat (next_gap) @(posedge clk_i);
    inp.valid <= 1'b1;
    inp.value <= value;
    do @(posedge clk_i); while (!inp.ready);
    convert_to_digits(value);
    next_gap = pick_gap(src_gaps_on);
    if (next_gap > 0) begin
      inp.valid <= 1'b0;
    end
  endtask

  task automatic release_input();
    if (next_gap == 0) begin
      inp.valid <= 1'b0;
    end
    next_gap = 0;
  endtask

  task automatic wait_drained();
    while (pending_digits.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic write, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (write && addr == ADDR_DIGIT_COUNT) begin
      digit_count_cfg = wdata[CNT_W-1:0];
    end
  endtask

  task automatic check_digit_count();
    logic [DATA_W-1:0] rd;
    apb_access(1'b0, ADDR_DIGIT_COUNT, '0, rd);
    if (rd !== DATA_W'(digit_count_cfg)) begin
      report_mismatch($sformatf("digit_count read %h want %h", rd, digit_count_cfg));
    end
  endtask

  task automatic set_digit_count(input logic [CNT_W-1:0] cnt);
    logic [DATA_W-1:0] rd;
    release_input();
    wait_drained();
    apb_access(1'b1, ADDR_DIGIT_COUNT, {28'($urandom), cnt}, rd);
    check_digit_count();
  endtask

  task automatic test_register_map();
    logic [DATA_W-1:0] rd;
    check_digit_count();
    // no register behind this address
    apb_access(1'b1, ADDR_UNUSED, 32'h0000_0002, rd);
    check_digit_count();
  endtask

  task automatic test_directed_values();
    // reset count of five
    send_value(16'd0);
    send_value(16'd1);
    send_value(16'd9);
    send_value(16'd10);
    send_value(16'hFFFF);
    send_value(16'h8000);
    send_value(16'h5555);
    send_value(16'hAAAA);
    send_value(16'd12345);
    set_digit_count(4'd1);
    send_value(16'd9);
    send_value(16'd10);
    send_value(16'hFFFF);
    // zero reads as one digit
    set_digit_count(4'd0);
    send_value(16'd0);
    send_value(16'd10);
    // above the maximum saturates
    set_digit_count(4'd15);
    send_value(16'hFFFF);
    send_value(16'd1);
    set_digit_count(4'd8);
    send_value(16'd0);
    send_value(16'hFFFF);
    set_digit_count(4'd4);
    send_value(16'd9999);
    send_value(16'd10000);
    release_input();
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    set_digit_count(4'd8);
    src_gaps_on   = 1'b0;
    sink_hold_req = 250;
    repeat (12) send_value(random_value());
    release_input();
    wait_drained();
    src_gaps_on = 1'b1;
  endtask

  task automatic test_sender_pause();
    set_digit_count(4'd3);
    repeat (3) begin
      repeat ($urandom_range(2, 6)) send_value(random_value());
      release_input();
      wait_drained();
    end
  endtask

  task automatic test_random_values();
    logic [CNT_W-1:0] phase_counts [8];
    phase_counts = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'd5, 4'd7, 4'd5};
    phase_counts[5] = CNT_W'($urandom_range(0, 15));
    for (int p = 0; p < 8; p++) begin
      set_digit_count(phase_counts[p]);
      // some phases run flat out on both sides
      src_gaps_on  = (p != 3 && p != 6);
      sink_gaps_on = (p != 3 && p != 6);
      repeat (63) send_value(random_value());
    end
    release_input();
    wait_drained();
    src_gaps_on  = 1'b1;
    sink_gaps_on = 1'b1;
  endtask

  initial begin : sink_ready
    int stall_left;
    stall_left = 0;
    outp.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_hold_req > 0) begin
        stall_left    = sink_hold_req;
        sink_hold_req = 0;
      end else if (stall_left == 0) begin
        stall_left = pick_gap(sink_gaps_on);
      end
      if (stall_left > 0) begin
        outp.ready <= 1'b0;
        stall_left--;
      end else begin
        outp.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : digit_checker
    digit_item_t want;
    if (rst_ni && outp.valid && outp.ready) begin
      if (pending_digits.size() == 0) begin
        report_mismatch($sformatf("unexpected item char %h last %b ovf %b",
                                  outp.digit_char, outp.last_digit, outp.overflow));
      end else begin
        want = pending_digits.pop_front();
        if (outp.digit_char !== want.digit_char) begin
          report_mismatch($sformatf("digit_char got %h want %h",
                                    outp.digit_char, want.digit_char));
        end
        if (outp.last_digit !== want.last_digit) begin
          report_mismatch($sformatf("last_digit got %b want %b",
                                    outp.last_digit, want.last_digit));
        end
        if (outp.overflow !== want.overflow) begin
          report_mismatch($sformatf("overflow got %b want %b",
                                    outp.overflow, want.overflow));
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("binary_to_decimal_ascii verification failed");
      $finish;
    end
  end

  initial begin : main
    error_count     = 0;
    cycle_count     = 0;
    next_gap        = 0;
    sink_hold_req   = 0;
    src_gaps_on     = 1'b1;
    sink_gaps_on    = 1'b1;
    digit_count_cfg = DIGIT_COUNT_RESET;
    rst_ni    <= 1'b0;
    inp.valid <= 1'b0;
    inp.value <= '0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_map();
    test_directed_values();
    test_output_backpressure();
    test_sender_pause();
    test_random_values();

    release_input();
    wait_drained();
    if (error_count == 0) begin
      $display("binary_to_decimal_ascii verification clean");
    end else begin
      $display("binary_to_decimal_ascii verification failed");
    end
    $finish;
  end

endmodule

// ===== binary_to_decimal_ascii.f =====
src/b2da_pkg.sv
src/b2da_if.sv
src/b2da_cfg.sv
src/b2da_conv.sv
src/b2da_ser.sv
src/binary_to_decimal_ascii.sv
src/b2da_chk.sv
dv/tb_binary_to_decimal_ascii.sv
